/* hw/rtl/gvc_pkg.sv */
package gvc_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int MAX_COLORS_DEF   = 256;
  localparam int VERTEX_W         = 12;
  localparam int COLOR_OUT_W      = 9;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]    colored_vertex;
    logic [COLOR_OUT_W-1:0] assigned_color;
    logic [COLOR_OUT_W-1:0] colors_in_use;
    logic                   overflow;
  } res_t;

endpackage

/* hw/rtl/gvc_ram.sv */
module gvc_ram #(
  parameter int DEPTH = gvc_pkg::MAX_VERTICES_DEF,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/gvc_seq.sv */
module gvc_seq #(
  parameter int MAX_VERTICES = gvc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_COLORS   = gvc_pkg::MAX_COLORS_DEF,
  localparam int VAW  = $clog2(MAX_VERTICES),
  localparam int CW   = $clog2(MAX_COLORS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gvc_pkg::VERTEX_W-1:0]  in_vertex,
  input  logic [gvc_pkg::VERTEX_W-1:0]  in_neighbor,
  input  logic                          in_has_neighbor,
  input  logic                          in_last_edge,
  output logic                          res_valid,
  output gvc_pkg::res_t                 res,
  input  logic                          res_take,
  output logic                          vs_we,
  output logic [VAW-1:0]                vs_waddr,
  output logic [CW-1:0]                 vs_wdata,
  output logic [VAW-1:0]                vs_raddr,
  input  logic [CW-1:0]                 vs_rdata,
  output logic                          mk_we,
  output logic [CW-1:0]                 mk_waddr,
  output logic                          mk_wdata,
  output logic [CW-1:0]                 mk_raddr,
  input  logic                          mk_rdata
);

  localparam int CNTW = CW + 1;
  localparam logic [CW-1:0]  MAXC     = CW'(MAX_COLORS);
  localparam logic [VAW-1:0] LAST_VTX = VAW'(MAX_VERTICES - 1);

  gvc_pkg::state_t state_r, state_nxt;
  logic [VAW-1:0]                clr_addr_r, clr_addr_nxt;
  logic [gvc_pkg::VERTEX_W-1:0]  vertex_r, vertex_nxt;
  logic                          v_ok_r, v_ok_nxt;
  logic                          last_r, last_nxt;
  logic                          look_v_r, look_v_nxt;
  logic [CW-1:0]                 max_color_r, max_color_nxt;
  logic [CNTW-1:0]               scan_c_r, scan_c_nxt;
  logic [CW-1:0]                 prev_addr_r, prev_addr_nxt;
  logic                          rd_v_r, rd_v_nxt;
  logic [CW-1:0]                 found_r, found_nxt;

  logic          issue;
  logic          open_new;
  logic [CW-1:0] chosen;
  logic [CW-1:0] max_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gvc_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      max_color_r <= '0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      max_color_r <= max_color_nxt;
      rd_v_r      <= rd_v_nxt;
    end
    vertex_r    <= vertex_nxt;
    v_ok_r      <= v_ok_nxt;
    last_r      <= last_nxt;
    look_v_r    <= look_v_nxt;
    scan_c_r    <= scan_c_nxt;
    prev_addr_r <= prev_addr_nxt;
    found_r     <= found_nxt;
  end

  assign issue    = scan_c_r <= {1'b0, max_color_r};
  assign open_new = (found_r == '0) && (max_color_r < MAXC);
  assign chosen   = (found_r != '0) ? found_r :
                    (open_new ? max_color_r + CW'(1) : '0);
  assign max_after = open_new ? max_color_r + CW'(1) : max_color_r;

  assign vs_raddr = VAW'(in_neighbor);
  assign mk_raddr = scan_c_r[CW-1:0];

  assign res.colored_vertex = vertex_r;
  assign res.assigned_color = gvc_pkg::COLOR_OUT_W'(chosen);
  assign res.colors_in_use  = gvc_pkg::COLOR_OUT_W'(max_after);
  assign res.overflow       = (found_r == '0) && !open_new;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    vertex_nxt    = vertex_r;
    v_ok_nxt      = v_ok_r;
    last_nxt      = last_r;
    look_v_nxt    = look_v_r;
    max_color_nxt = max_color_r;
    scan_c_nxt    = scan_c_r;
    prev_addr_nxt = prev_addr_r;
    rd_v_nxt      = rd_v_r;
    found_nxt     = found_r;
    in_stall      = 1'b1;
    res_valid     = 1'b0;
    vs_we         = 1'b0;
    vs_waddr      = VAW'(vertex_r);
    vs_wdata      = chosen;
    mk_we         = 1'b0;
    mk_waddr      = prev_addr_r;
    mk_wdata      = 1'b0;

    case (state_r)
      gvc_pkg::ST_CLEAR: begin
        vs_we    = 1'b1;
        vs_waddr = clr_addr_r;
        vs_wdata = '0;
        clr_addr_nxt = clr_addr_r + VAW'(1);
        if (clr_addr_r == LAST_VTX) begin
          state_nxt = gvc_pkg::ST_IDLE;
        end
      end
      gvc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          vertex_nxt = in_vertex;
          v_ok_nxt   = 32'(in_vertex) < 32'(MAX_VERTICES);
          last_nxt   = in_last_edge;
          look_v_nxt = in_has_neighbor && (32'(in_neighbor) < 32'(MAX_VERTICES));
          state_nxt  = gvc_pkg::ST_MARK;
        end
      end
      gvc_pkg::ST_MARK: begin
        mk_we    = look_v_r && (vs_rdata != '0);
        mk_waddr = vs_rdata;
        mk_wdata = 1'b1;
        scan_c_nxt = CNTW'(1);
        rd_v_nxt   = 1'b0;
        found_nxt  = '0;
        state_nxt  = last_r ? gvc_pkg::ST_SCAN : gvc_pkg::ST_IDLE;
      end
      gvc_pkg::ST_SCAN: begin
        // read ahead one entry; clear each entry once its value is back
        mk_we    = rd_v_r;
        mk_waddr = prev_addr_r;
        mk_wdata = 1'b0;
        if (rd_v_r && !mk_rdata && (found_r == '0)) begin
          found_nxt = prev_addr_r;
        end
        rd_v_nxt      = issue;
        prev_addr_nxt = scan_c_r[CW-1:0];
        if (issue) begin
          scan_c_nxt = scan_c_r + CNTW'(1);
        end else begin
          state_nxt = gvc_pkg::ST_DONE;
        end
      end
      gvc_pkg::ST_DONE: begin
        res_valid = 1'b1;
        // a freshly opened color starts with a clean mark
        mk_we    = res_take && open_new;
        mk_waddr = max_color_r + CW'(1);
        mk_wdata = 1'b0;
        vs_we    = res_take && v_ok_r;
        if (res_take) begin
          max_color_nxt = max_after;
          state_nxt     = gvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/greedy_vertex_coloring_top.sv */
// Greedy vertex coloring over an edge stream.
// Input channel (in_*): one beat per out-edge of the vertex being colored, or a
// single beat with in_has_neighbor low for a vertex without edges; the beat
// with in_last_edge high closes the vertex. Output channel (out_*): one beat per
// closed vertex with its color (0 on overflow), the number of colors opened so
// far and the overflow flag. Both channels use valid/stall.
// Per beat: a non-last beat goes through a color store read and a mark write;
// no new beat is taken until the block is back in idle. A last beat adds the
// scan over the mark memory, which walks colors 1..max_color one entry per
// cycle and clears each mark as it goes; the result then waits in the done
// state until the output register takes it.
// Reset: after rst_n is released the color store is cleared one entry per cycle,
// all MAX_VERTICES entries, with in_stall held high.
// A stalled output beat holds; one finished result waits in the output register
// while the next vertex's edges are taken; beyond its busy states the block
// stalls its input only while a second result waits on a stalled output beat.
module greedy_vertex_coloring_top #(
  parameter int MAX_VERTICES = gvc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_COLORS   = gvc_pkg::MAX_COLORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gvc_pkg::VERTEX_W-1:0]    in_vertex,
  input  logic [gvc_pkg::VERTEX_W-1:0]    in_neighbor,
  input  logic                            in_has_neighbor,
  input  logic                            in_last_edge,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gvc_pkg::VERTEX_W-1:0]    out_colored_vertex,
  output logic [gvc_pkg::COLOR_OUT_W-1:0] out_assigned_color,
  output logic [gvc_pkg::COLOR_OUT_W-1:0] out_colors_in_use,
  output logic                            out_overflow
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_COLORS + 1);

  logic           vs_we;
  logic [VAW-1:0] vs_waddr;
  logic [CW-1:0]  vs_wdata;
  logic [VAW-1:0] vs_raddr;
  logic [CW-1:0]  vs_rdata;
  logic           mk_we;
  logic [CW-1:0]  mk_waddr;
  logic           mk_wdata;
  logic [CW-1:0]  mk_raddr;
  logic           mk_rdata;

  logic          res_valid;
  logic          res_take;
  gvc_pkg::res_t res;

  logic          out_valid_r, out_valid_nxt;
  gvc_pkg::res_t out_r;

  gvc_ram #(
    .DEPTH(MAX_VERTICES),
    .WIDTH(CW)
  ) u_vstore (
    .clk  (clk),
    .we   (vs_we),
    .waddr(vs_waddr),
    .wdata(vs_wdata),
    .raddr(vs_raddr),
    .rdata(vs_rdata)
  );

  gvc_ram #(
    .DEPTH(MAX_COLORS + 1),
    .WIDTH(1)
  ) u_marks (
    .clk  (clk),
    .we   (mk_we),
    .waddr(mk_waddr),
    .wdata(mk_wdata),
    .raddr(mk_raddr),
    .rdata(mk_rdata)
  );

  gvc_seq #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_COLORS  (MAX_COLORS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_vertex      (in_vertex),
    .in_neighbor    (in_neighbor),
    .in_has_neighbor(in_has_neighbor),
    .in_last_edge   (in_last_edge),
    .res_valid      (res_valid),
    .res            (res),
    .res_take       (res_take),
    .vs_we          (vs_we),
    .vs_waddr       (vs_waddr),
    .vs_wdata       (vs_wdata),
    .vs_raddr       (vs_raddr),
    .vs_rdata       (vs_rdata),
    .mk_we          (mk_we),
    .mk_waddr       (mk_waddr),
    .mk_wdata       (mk_wdata),
    .mk_raddr       (mk_raddr),
    .mk_rdata       (mk_rdata)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_colored_vertex = out_r.colored_vertex;
  assign out_assigned_color = out_r.assigned_color;
  assign out_colors_in_use  = out_r.colors_in_use;
  assign out_overflow       = out_r.overflow;

endmodule

/* hw/rtl/gvc_checker.sv */
module gvc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [gvc_pkg::VERTEX_W-1:0]    in_vertex,
  input logic [gvc_pkg::VERTEX_W-1:0]    in_neighbor,
  input logic                            in_has_neighbor,
  input logic                            in_last_edge,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [gvc_pkg::VERTEX_W-1:0]    out_colored_vertex,
  input logic [gvc_pkg::COLOR_OUT_W-1:0] out_assigned_color,
  input logic [gvc_pkg::COLOR_OUT_W-1:0] out_colors_in_use,
  input logic                            out_overflow
);

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_colored_vertex)
      && $stable(out_assigned_color) && $stable(out_colors_in_use)
      && $stable(out_overflow))
    else $error("output beat changed while stalled");

  // an accepted edge beat keeps the block busy, so the input stalls after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  a_ovf_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_assigned_color == '0)
    else $error("overflow beat carries a color");

  a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |->
      out_assigned_color != '0 && out_assigned_color <= out_colors_in_use)
    else $error("assigned color outside opened range");

endmodule

bind greedy_vertex_coloring_top gvc_checker u_gvc_checker (.*);

/* tb/sv/tb.sv */
module tb;

  localparam int VW  = gvc_pkg::VERTEX_W;
  localparam int CLW = gvc_pkg::COLOR_OUT_W;

  localparam int MAX_V = gvc_pkg::MAX_VERTICES_DEF;
  localparam int MAX_C = gvc_pkg::MAX_COLORS_DEF;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [VW-1:0] neighbor;
    logic          has_nb;
    logic          last;
  } edge_beat_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [VW-1:0]  in_vertex = '0;
  logic [VW-1:0]  in_neighbor = '0;
  logic           in_has_neighbor = 1'b0;
  logic           in_last_edge = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [VW-1:0]  out_colored_vertex;
  logic [CLW-1:0] out_assigned_color;
  logic [CLW-1:0] out_colors_in_use;
  logic           out_overflow;

  edge_beat_t    edge_beats[$];
  gvc_pkg::res_t color_results[$];
  edge_beat_t    nxt;
  gvc_pkg::res_t want;

  bit [CLW-1:0] vtx_color [MAX_V];
  bit           color_seen [1:MAX_C];
  int unsigned  open_colors = 0;

  int n_fail = 0;
  int n_beats = 0;
  int n_popped = 0;
  int n_colored = 0;
  int n_ovf = 0;
  int quiet_from = 0;
  logic [2:0] in_gap = '0;
  logic [2:0] out_gap = '0;

  greedy_vertex_coloring_top #(
    .MAX_VERTICES(MAX_V),
    .MAX_COLORS  (MAX_C)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_vertex         (in_vertex),
    .in_neighbor       (in_neighbor),
    .in_has_neighbor   (in_has_neighbor),
    .in_last_edge      (in_last_edge),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_colored_vertex(out_colored_vertex),
    .out_assigned_color(out_assigned_color),
    .out_colors_in_use (out_colors_in_use),
    .out_overflow      (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_coloring(logic [VW-1:0] v, logic [VW-1:0] nb,
                                           logic has_nb, logic last);
    logic [CLW-1:0] pick;
    logic           ovf;
    gvc_pkg::res_t  r;
    pick = '0;
    ovf = 1'b0;
    if (has_nb && nb < MAX_V && vtx_color[nb] != 0 && vtx_color[nb] <= MAX_C) begin
      color_seen[vtx_color[nb]] = 1'b1;
    end
    if (last) begin
      for (int c = 1; c <= MAX_C; c++) begin
        if (pick == 0 && c <= open_colors && !color_seen[c]) pick = CLW'(c);
      end
      if (pick == 0) begin
        if (open_colors < MAX_C) begin
          open_colors++;
          pick = CLW'(open_colors);
        end else begin
          ovf = 1'b1;
        end
      end
      if (v < MAX_V) vtx_color[v] = pick;
      for (int c = 1; c <= MAX_C; c++) color_seen[c] = 1'b0;
      r.colored_vertex = v;
      r.assigned_color = pick;
      r.colors_in_use  = CLW'(open_colors);
      r.overflow       = ovf;
      color_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string fname, logic [31:0] exp_val,
                                      logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", fname, exp_val, act_val);
      n_fail++;
    end
  endfunction

  task automatic add_beat(int v, int nb, logic has_nb, logic last);
    edge_beat_t b;
    b.vertex   = VW'(v);
    b.neighbor = VW'(nb);
    b.has_nb   = has_nb;
    b.last     = last;
    edge_beats.push_back(b);
  endtask

  // mostly a small hot set so neighbors are colored, sometimes any id
  function automatic int pick_id();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(0, 39);
    if (r < 18) return $urandom_range(0, MAX_V - 1);
    return $urandom_range(0, 4095);
  endfunction

  task automatic add_random_vertex();
    int v;
    int deg;
    v = pick_id();
    deg = $urandom_range(0, 7);
    if (deg == 0) begin
      add_beat(v, $urandom_range(0, 4095), 1'b0, 1'b1);
    end else begin
      for (int e = 0; e < deg; e++) begin
        add_beat(($urandom_range(0, 19) == 0) ? pick_id() : v, pick_id(),
                 $urandom_range(0, 15) != 0, e == deg - 1);
      end
    end
  endtask

  // each member sees every earlier member: forces new colors
  task automatic add_clique(int k);
    int base;
    int rot;
    base = $urandom_range(100, 1000 - k);
    for (int j = 0; j < k; j++) begin
      rot = $urandom_range(0, 31);
      if (j == 0) begin
        add_beat(base, $urandom_range(0, 4095), 1'b0, 1'b1);
      end else begin
        for (int t = 0; t < j; t++) begin
          add_beat(base + j, base + (rot + t) % j, 1'b1, t == j - 1);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_coloring(in_vertex, in_neighbor, in_has_neighbor, in_last_edge);
        n_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 3'd1;
        end else if (edge_beats.size() != 0 &&
                     (n_popped >= quiet_from || $urandom_range(0, 4) != 0)) begin
          nxt = edge_beats.pop_front();
          n_popped++;
          in_valid        <= 1'b1;
          in_vertex       <= nxt.vertex;
          in_neighbor     <= nxt.neighbor;
          in_has_neighbor <= nxt.has_nb;
          in_last_edge    <= nxt.last;
        end else begin
          in_valid <= 1'b0;
          if (edge_beats.size() != 0) in_gap <= 3'($urandom_range(0, 5));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (color_results.size() == 0) begin
          $error("unexpected result beat: vertex %0d color %0d", out_colored_vertex,
                 out_assigned_color);
          n_fail++;
        end else begin
          want = color_results.pop_front();
          n_colored++;
          if (want.overflow) n_ovf++;
          check_field("colored_vertex", 32'(want.colored_vertex), 32'(out_colored_vertex));
          check_field("assigned_color", 32'(want.assigned_color), 32'(out_assigned_color));
          check_field("colors_in_use", 32'(want.colors_in_use), 32'(out_colors_in_use));
          check_field("overflow", 32'(want.overflow), 32'(out_overflow));
        end
      end
      if (out_gap != 0) begin
        out_stall <= 1'b1;
        out_gap   <= out_gap - 3'd1;
      end else if (n_popped < quiet_from && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        out_gap   <= 3'($urandom_range(0, 5));
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10000000;
    $display("** greedy_vertex_coloring_top: FAILED **");
    $finish;
  end

  initial begin
    add_beat(5, 0, 1'b0, 1'b1);        // no edges, first color opened
    add_beat(6, 5, 1'b1, 1'b1);
    add_beat(7, 5, 1'b1, 1'b0);
    add_beat(7, 6, 1'b1, 1'b1);
    add_beat(8, 4095, 1'b1, 1'b0);     // highest neighbor id, still uncolored
    add_beat(8, 7, 1'b0, 1'b1);        // neighbor field ignored
    add_beat(4095, 6, 1'b1, 1'b0);     // highest vertex id
    add_beat(4095, 8, 1'b1, 1'b1);
    add_beat(9, 4095, 1'b1, 1'b1);
    add_beat(10, 5, 1'b1, 1'b0);       // vertex id changes mid-list
    add_beat(11, 6, 1'b1, 1'b1);
    add_beat(11, 11, 1'b1, 1'b1);      // self-edge, recolor
    add_beat(0, 0, 1'b1, 1'b1);
    add_beat(MAX_V - 1, 0, 1'b1, 1'b0);
    add_beat(MAX_V - 1, MAX_V - 1, 1'b1, 1'b1);
    add_beat(MAX_V - 2, 0, 1'b1, 1'b1);
    add_beat(12, MAX_V - 2, 1'b1, 1'b0);
    add_beat(12, 0, 1'b1, 1'b1);
    for (int seg = 0; seg < 4; seg++) begin
      repeat (20) add_random_vertex();
      if (seg % 2 == 1) add_clique($urandom_range(17, 19));
    end
    while (edge_beats.size() < 600) add_random_vertex();
    quiet_from = edge_beats.size() * 85 / 100;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (in_valid || edge_beats.size() != 0) @(posedge clk);
    while (color_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (color_results.size() != 0) begin
      $error("%0d expected colorings never arrived", color_results.size());
      n_fail++;
    end
    $display("edge beats: %0d, vertices colored and checked: %0d", n_beats, n_colored);
    $display("overflow results: %0d, colors opened: %0d of %0d", n_ovf, open_colors, MAX_C);
    if (n_fail == 0) begin
      $display("** greedy_vertex_coloring_top: PASSED **");
    end else begin
      $display("** greedy_vertex_coloring_top: FAILED **");
    end
    $finish;
  end

endmodule

/* greedy_vertex_coloring_top.f */
hw/rtl/gvc_pkg.sv
hw/rtl/gvc_ram.sv
hw/rtl/gvc_seq.sv
hw/rtl/greedy_vertex_coloring_top.sv
hw/rtl/gvc_checker.sv
tb/sv/tb.sv
